/* design/nnf_pkg.sv */
// nnf_pkg: shared types, character codes and the frequency rom for the
// note name to frequency parser. no dependencies.
package nnf_pkg;

  localparam int unsigned OCTAVE_COUNT     = 9;
  localparam int unsigned NOTES_PER_OCTAVE = 12;

  localparam logic [3:0] OCT_MAG_MAX = 4'd15;
  localparam logic [3:0] SEMI_TOP    = 4'd11;

  // character codes
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_B  = 8'h42;
  localparam logic [7:0] CHAR_UP_F  = 8'h46;
  localparam logic [7:0] CHAR_UP_G  = 8'h47;
  localparam logic [7:0] CHAR_UP_S  = 8'h53;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_B  = 8'h62;
  localparam logic [7:0] CHAR_LO_F  = 8'h66;
  localparam logic [7:0] CHAR_LO_G  = 8'h67;
  localparam logic [7:0] CHAR_LO_S  = 8'h73;
  localparam logic [7:0] CASE_GAP   = 8'h20;

  // accidental codes
  localparam logic [1:0] ACC_NONE  = 2'd0;
  localparam logic [1:0] ACC_SHARP = 2'd1;
  localparam logic [1:0] ACC_FLAT  = 2'd2;

  // status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_MALFORMED = 2'd1;
  localparam logic [1:0] STATUS_RANGE     = 2'd2;

  typedef enum logic [6:0] {
    PH_LEAD   = 7'b0000001,
    PH_ACC    = 7'b0000010,
    PH_GAP    = 7'b0000100,
    PH_SIGN   = 7'b0001000,
    PH_DIGITS = 7'b0010000,
    PH_TAIL   = 7'b0100000,
    PH_ERR    = 7'b1000000
  } nnf_phase_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [12:0] frequency_hz;
  } nnf_result_t;

  // semitone of letters A..G
  localparam logic [3:0] LETTER_SEMI [0:6] = '{
    4'd9, 4'd11, 4'd0, 4'd2, 4'd4, 4'd5, 4'd7
  };

  // rounded 12-tet frequencies, C0 .. B8
  localparam logic [12:0] FREQ_ROM [0:OCTAVE_COUNT-1][0:NOTES_PER_OCTAVE-1] = '{
    '{13'd16,   13'd17,   13'd18,   13'd19,   13'd21,   13'd22,
      13'd23,   13'd25,   13'd26,   13'd28,   13'd29,   13'd31},
    '{13'd33,   13'd35,   13'd37,   13'd39,   13'd41,   13'd44,
      13'd46,   13'd49,   13'd52,   13'd55,   13'd58,   13'd62},
    '{13'd65,   13'd69,   13'd73,   13'd78,   13'd82,   13'd87,
      13'd92,   13'd98,   13'd104,  13'd110,  13'd117,  13'd123},
    '{13'd131,  13'd139,  13'd147,  13'd156,  13'd165,  13'd175,
      13'd185,  13'd196,  13'd208,  13'd220,  13'd233,  13'd247},
    '{13'd262,  13'd277,  13'd294,  13'd311,  13'd330,  13'd349,
      13'd370,  13'd392,  13'd415,  13'd440,  13'd466,  13'd494},
    '{13'd523,  13'd554,  13'd587,  13'd622,  13'd659,  13'd698,
      13'd740,  13'd784,  13'd831,  13'd880,  13'd932,  13'd988},
    '{13'd1047, 13'd1109, 13'd1175, 13'd1245, 13'd1319, 13'd1397,
      13'd1480, 13'd1568, 13'd1661, 13'd1760, 13'd1865, 13'd1976},
    '{13'd2093, 13'd2217, 13'd2349, 13'd2489, 13'd2637, 13'd2794,
      13'd2960, 13'd3136, 13'd3322, 13'd3520, 13'd3729, 13'd3951},
    '{13'd4186, 13'd4435, 13'd4699, 13'd4978, 13'd5274, 13'd5588,
      13'd5920, 13'd6272, 13'd6645, 13'd7040, 13'd7459, 13'd7902}
  };

endpackage

/* design/nnf_if.sv */
// nnf_if: valid/ready channel interfaces for the character input and the
// result output. depends on nothing.
interface nnf_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface nnf_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [12:0] frequency_hz;

  modport source (output valid, output status, output frequency_hz, input ready);
  modport sink   (input valid, input status, input frequency_hz, output ready);
endinterface

/* design/note_name_to_frequency_parser.sv */
// note name to frequency parser: one character of a note name per request,
// a zero byte ends the name and yields one status/frequency result.
// throughput is one character per clock while no terminator stalls: the parse
// state updates in a single pass between the input register and the result
// register, so every character other than a stalled terminator is retired in
// the cycle after it is taken. a terminator passes through the input register
// and then loads the result register, which presents it on the output. the
// only stall is a terminator waiting in the input register while the
// previous result has not been taken; other characters never wait on the
// output side. the result carries status 0 (ok), 1 (malformed name)
// or 2 (octave outside 0..8) and the rounded 12-tet frequency in hertz,
// which is 0 unless the status is ok. each terminator rearms the parser.
// depends on nnf_pkg, nnf_if and nnf_parse.
module note_name_to_frequency_parser import nnf_pkg::*; (
  input logic          clk,
  input logic          rst_n,
  nnf_char_if.sink     in_ch,
  nnf_result_if.source out_ch
);

  // input register
  logic        in_valid_r, in_valid_nxt;
  logic [7:0]  in_char_r;
  logic        in_term;
  logic        advance;
  logic        in_ready;

  // result register
  logic        out_valid_r, out_valid_nxt;
  nnf_result_t out_res_r;
  nnf_result_t parse_res;
  logic        out_load;

  assign in_term = (in_char_r == CHAR_NUL);

  // a character retires unless it is a terminator and the result slot is full and not being taken
  assign advance  = in_valid_r && (!in_term || !out_valid_r || out_ch.ready);
  assign in_ready = !in_valid_r || advance;
  assign out_load = advance && in_term;

  assign in_ch.ready = in_ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_ready) begin
      in_valid_nxt = in_ch.valid;
    end
    out_valid_nxt = out_load || (out_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      in_char_r <= in_ch.char_code;
    end
    if (out_load) begin
      out_res_r <= parse_res;
    end
  end

  // parse state machine, stepped once per retired character
  nnf_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .char_code (in_char_r),
    .result    (parse_res)
  );

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_res_r.status;
  assign out_ch.frequency_hz = out_res_r.frequency_hz;

`ifndef NO_ASSERTIONS
  // a held result is never overwritten by a new terminator
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !out_load)
    else $error("result overwritten while stalled");

  // a retired terminator always presents a result next cycle
  a_term_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("terminator produced no result");

  // the input side only stalls behind a held terminator and a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_valid_r && in_term && out_valid_r && !out_ch.ready))
    else $error("input stalled without cause");

  // non-ok results carry no frequency
  a_freq_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.status != STATUS_OK) |-> (out_res_r.frequency_hz == 13'd0))
    else $error("frequency on failed result");
`endif

endmodule

/* design/nnf_parse.sv */
// nnf_parse: note name parse state machine and terminator evaluation.
// depends on nnf_pkg.
module nnf_parse import nnf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  logic [7:0]  char_code,
  output nnf_result_t result
);

  nnf_phase_t  phase_r, phase_nxt;
  logic [3:0]  semitone_r, semitone_nxt;
  logic [1:0]  acc_r, acc_nxt;
  logic [3:0]  mag_r, mag_nxt;
  logic        neg_r, neg_nxt;

  logic        is_ws, is_digit, is_letter, is_sharp, is_flat;
  logic [7:0]  upper;
  logic [2:0]  letter_idx;
  logic [3:0]  digit;
  logic [7:0]  dec_v;
  nnf_phase_t  gap_phase;
  logic [3:0]  gap_mag;
  logic        gap_neg;

  logic signed [5:0] oct_s;
  logic [3:0]        note_idx;

  // character classes
  always_comb begin
    is_ws     = (char_code == CHAR_SPACE) ||
                (char_code >= CHAR_TAB && char_code <= CHAR_CR);
    is_digit  = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    upper     = (char_code >= CHAR_LO_A && char_code <= CHAR_LO_G) ?
                (char_code - CASE_GAP) : char_code;
    is_letter = (upper >= CHAR_UP_A) && (upper <= CHAR_UP_G);
    letter_idx = 3'(upper - CHAR_UP_A);
    is_sharp  = (char_code == CHAR_HASH) || (char_code == CHAR_LO_S) ||
                (char_code == CHAR_UP_S);
    is_flat   = (char_code == CHAR_LO_B) || (char_code == CHAR_UP_B) ||
                (char_code == CHAR_LO_F) || (char_code == CHAR_UP_F);
    digit     = char_code[3:0];
    dec_v     = {1'b0, mag_r, 3'b000} + {3'b000, mag_r, 1'b0} + {4'b0000, digit};
  end

  // whitespace-before-octave handling, shared by two phases
  always_comb begin
    gap_phase = PH_ERR;
    gap_mag   = mag_r;
    gap_neg   = neg_r;
    if (is_ws) begin
      gap_phase = PH_GAP;
    end else if (char_code == CHAR_PLUS || char_code == CHAR_MINUS) begin
      gap_neg   = (char_code == CHAR_MINUS);
      gap_phase = PH_SIGN;
    end else if (is_digit) begin
      gap_mag   = digit;
      gap_phase = PH_DIGITS;
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    semitone_nxt = semitone_r;
    acc_nxt      = acc_r;
    mag_nxt      = mag_r;
    neg_nxt      = neg_r;
    if (step_en) begin
      if (char_code == CHAR_NUL) begin
        // terminator rearms the parser
        phase_nxt    = PH_LEAD;
        semitone_nxt = 4'd0;
        acc_nxt      = ACC_NONE;
        mag_nxt      = 4'd0;
        neg_nxt      = 1'b0;
      end else begin
        unique case (phase_r)
          PH_LEAD: begin
            if (!is_ws) begin
              if (is_letter) begin
                semitone_nxt = LETTER_SEMI[letter_idx];
                phase_nxt    = PH_ACC;
              end else begin
                phase_nxt = PH_ERR;
              end
            end
          end
          PH_ACC: begin
            if (is_sharp) begin
              acc_nxt   = ACC_SHARP;
              phase_nxt = PH_GAP;
            end else if (is_flat) begin
              acc_nxt   = ACC_FLAT;
              phase_nxt = PH_GAP;
            end else begin
              phase_nxt = gap_phase;
              mag_nxt   = gap_mag;
              neg_nxt   = gap_neg;
            end
          end
          PH_GAP: begin
            phase_nxt = gap_phase;
            mag_nxt   = gap_mag;
            neg_nxt   = gap_neg;
          end
          PH_SIGN: begin
            if (is_digit) begin
              mag_nxt   = digit;
              phase_nxt = PH_DIGITS;
            end else begin
              phase_nxt = PH_ERR;
            end
          end
          PH_DIGITS: begin
            if (is_digit) begin
              mag_nxt = (dec_v > {4'b0000, OCT_MAG_MAX}) ? OCT_MAG_MAX : dec_v[3:0];
            end else begin
              phase_nxt = PH_TAIL;
            end
          end
          PH_TAIL: begin
          end
          PH_ERR: begin
          end
          default: phase_nxt = PH_ERR;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_LEAD;
      semitone_r <= 4'd0;
      acc_r      <= ACC_NONE;
      mag_r      <= 4'd0;
      neg_r      <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      semitone_r <= semitone_nxt;
      acc_r      <= acc_nxt;
      mag_r      <= mag_nxt;
      neg_r      <= neg_nxt;
    end
  end

  // evaluation of the collected fields, used on the terminator
  always_comb begin
    oct_s    = neg_r ? -$signed({2'b00, mag_r}) : $signed({2'b00, mag_r});
    note_idx = semitone_r;
    if (acc_r == ACC_SHARP) begin
      if (semitone_r == SEMI_TOP) begin
        note_idx = 4'd0;
        oct_s    = oct_s + 6'sd1;
      end else begin
        note_idx = semitone_r + 4'd1;
      end
    end else if (acc_r == ACC_FLAT) begin
      if (semitone_r == 4'd0) begin
        note_idx = SEMI_TOP;
        oct_s    = oct_s - 6'sd1;
      end else begin
        note_idx = semitone_r - 4'd1;
      end
    end

    result.status       = STATUS_MALFORMED;
    result.frequency_hz = 13'd0;
    if (phase_r == PH_DIGITS || phase_r == PH_TAIL) begin
      if (oct_s < 6'sd0 || oct_s > 6'sd8) begin
        result.status = STATUS_RANGE;
      end else begin
        result.status       = STATUS_OK;
        result.frequency_hz = FREQ_ROM[oct_s[3:0]][note_idx];
      end
    end
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// tb_top: self-checking bench for note_name_to_frequency_parser, directed and random note names
// depends on nnf_pkg and nnf_if, and on the parser rtl
module tb_top;
  import nnf_pkg::*;

  localparam int CHAR_TARGET    = 750;   // characters before the random names stop
  localparam int IDLE_LIMIT     = 2000;  // cycles without any handshake before giving up
  localparam int DRAIN_CYCLES   = 8;     // wait after the last expected result, for anything stray

  // own copy of the 12-tet table, C0 .. B8, rounded to whole hertz
  localparam logic [12:0] NOTE_HZ [0:8][0:11] = '{
    '{13'd16,   13'd17,   13'd18,   13'd19,   13'd21,   13'd22,
      13'd23,   13'd25,   13'd26,   13'd28,   13'd29,   13'd31},
    '{13'd33,   13'd35,   13'd37,   13'd39,   13'd41,   13'd44,
      13'd46,   13'd49,   13'd52,   13'd55,   13'd58,   13'd62},
    '{13'd65,   13'd69,   13'd73,   13'd78,   13'd82,   13'd87,
      13'd92,   13'd98,   13'd104,  13'd110,  13'd117,  13'd123},
    '{13'd131,  13'd139,  13'd147,  13'd156,  13'd165,  13'd175,
      13'd185,  13'd196,  13'd208,  13'd220,  13'd233,  13'd247},
    '{13'd262,  13'd277,  13'd294,  13'd311,  13'd330,  13'd349,
      13'd370,  13'd392,  13'd415,  13'd440,  13'd466,  13'd494},
    '{13'd523,  13'd554,  13'd587,  13'd622,  13'd659,  13'd698,
      13'd740,  13'd784,  13'd831,  13'd880,  13'd932,  13'd988},
    '{13'd1047, 13'd1109, 13'd1175, 13'd1245, 13'd1319, 13'd1397,
      13'd1480, 13'd1568, 13'd1661, 13'd1760, 13'd1865, 13'd1976},
    '{13'd2093, 13'd2217, 13'd2349, 13'd2489, 13'd2637, 13'd2794,
      13'd2960, 13'd3136, 13'd3322, 13'd3520, 13'd3729, 13'd3951},
    '{13'd4186, 13'd4435, 13'd4699, 13'd4978, 13'd5274, 13'd5588,
      13'd5920, 13'd6272, 13'd6645, 13'd7040, 13'd7459, 13'd7902}
  };

  // semitone of the natural letters A .. G
  localparam logic [3:0] LETTER_TO_SEMI [0:6] = '{
    4'd9, 4'd11, 4'd0, 4'd2, 4'd4, 4'd5, 4'd7
  };

  logic clk;
  logic rst_n;

  nnf_char_if   name_chars ();
  nnf_result_if note_results ();

  note_name_to_frequency_parser i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (name_chars),
    .out_ch (note_results)
  );

  // parser state as predicted by the bench
  nnf_phase_t  name_phase;
  logic [3:0]  note_semi;
  logic [1:0]  note_acc;
  logic [3:0]  oct_mag;
  logic        oct_neg;

  nnf_result_t expected_notes [$];

  int chars_sent;
  int notes_checked;
  int notes_ok;
  int notes_malformed;
  int notes_range;
  int error_count;

  // sender and receiver pacing
  bit tx_bursty;
  int burst_left;
  bit rx_always;
  int rx_mode;
  int rx_cycle;
  int rx_run_left;
  bit rx_run_high;
  logic rx_next;

  int idle_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_space(input logic [7:0] c);
    return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CHAR_ZERO && c <= CHAR_NINE;
  endfunction

  function automatic void clear_parser();
    name_phase = PH_LEAD;
    note_semi  = 4'd0;
    note_acc   = ACC_NONE;
    oct_mag    = 4'd0;
    oct_neg    = 1'b0;
  endfunction

  // whitespace, sign or first digit before the octave
  function automatic void take_octave_start(input logic [7:0] c);
    if (is_space(c)) begin
      name_phase = PH_GAP;
    end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
      oct_neg    = (c == CHAR_MINUS);
      name_phase = PH_SIGN;
    end else if (is_digit(c)) begin
      oct_mag    = 4'(c - CHAR_ZERO);
      name_phase = PH_DIGITS;
    end else begin
      name_phase = PH_ERR;
    end
  endfunction

  // status and frequency for the name collected so far
  function automatic nnf_result_t close_note();
    nnf_result_t r;
    int oct;
    int idx;
    r.status       = STATUS_MALFORMED;
    r.frequency_hz = '0;
    if (name_phase == PH_DIGITS || name_phase == PH_TAIL) begin
      oct = oct_mag;
      if (oct_neg) oct = -oct;
      idx = note_semi;
      if (note_acc == ACC_SHARP) idx++;
      else if (note_acc == ACC_FLAT) idx--;
      // b sharp and c flat cross into the neighboring octave
      if (idx < 0) begin
        idx += 12;
        oct--;
      end
      if (idx >= 12) begin
        idx -= 12;
        oct++;
      end
      if (oct < 0 || oct > 8) begin
        r.status = STATUS_RANGE;
      end else begin
        r.status       = STATUS_OK;
        r.frequency_hz = NOTE_HZ[oct][idx];
      end
    end
    return r;
  endfunction

  // advance the predicted parser by one accepted character
  function automatic void parse_char(input logic [7:0] c);
    logic [7:0] u;
    int         v;
    if (c == CHAR_NUL) begin
      expected_notes.push_back(close_note());
      clear_parser();
      return;
    end
    case (name_phase)
      PH_LEAD: begin
        if (!is_space(c)) begin
          u = c;
          if (u >= CHAR_LO_A && u <= CHAR_LO_G) u = u - CASE_GAP;
          if (u >= CHAR_UP_A && u <= CHAR_UP_G) begin
            note_semi  = LETTER_TO_SEMI[u - CHAR_UP_A];
            name_phase = PH_ACC;
          end else begin
            name_phase = PH_ERR;
          end
        end
      end
      PH_ACC: begin
        // accidental only right after the letter
        if (c == CHAR_HASH || c == CHAR_LO_S || c == CHAR_UP_S) begin
          note_acc   = ACC_SHARP;
          name_phase = PH_GAP;
        end else if (c == CHAR_LO_B || c == CHAR_UP_B || c == CHAR_LO_F || c == CHAR_UP_F) begin
          note_acc   = ACC_FLAT;
          name_phase = PH_GAP;
        end else begin
          take_octave_start(c);
        end
      end
      PH_GAP: take_octave_start(c);
      PH_SIGN: begin
        if (is_digit(c)) begin
          oct_mag    = 4'(c - CHAR_ZERO);
          name_phase = PH_DIGITS;
        end else begin
          name_phase = PH_ERR;
        end
      end
      PH_DIGITS: begin
        if (is_digit(c)) begin
          // magnitude saturates at 15
          v       = oct_mag * 10 + (c - CHAR_ZERO);
          oct_mag = (v > 15) ? 4'd15 : 4'(v);
        end else begin
          name_phase = PH_TAIL;
        end
      end
      PH_TAIL: ;
      default: name_phase = PH_ERR;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result checker: each accepted result against the oldest expected note
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : note_checker
    nnf_result_t want;
    if (rst_n && note_results.valid && note_results.ready) begin
      if (expected_notes.size() == 0) begin
        $error("unexpected result: status %0d, frequency_hz %0d",
               note_results.status, note_results.frequency_hz);
        error_count++;
      end else begin
        want = expected_notes.pop_front();
        notes_checked++;
        case (want.status)
          STATUS_OK:        notes_ok++;
          STATUS_MALFORMED: notes_malformed++;
          default:          notes_range++;
        endcase
        if (note_results.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, note_results.status);
          error_count++;
        end
        if (note_results.frequency_hz !== want.frequency_hz) begin
          $error("frequency_hz: expected %0d, got %0d",
                 want.frequency_hz, note_results.frequency_hz);
          error_count++;
        end
      end
    end
  end

  // watchdog: any handshake on either side resets the count
  always @(posedge clk) begin
    if ((name_chars.valid && name_chars.ready) || (note_results.valid && note_results.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no request for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: stall pattern, redrawn at random, among always ready,
  // random, periodic and long on/off runs
  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 192 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: rx_next = 1'b1;
      1: rx_next = ($urandom_range(0, 3) != 0);
      2: rx_next = ((rx_cycle % 9) < 5);
      default: begin
        if (rx_run_left == 0) begin
          rx_run_left = $urandom_range(1, 20);
          rx_run_high = !rx_run_high;
        end
        rx_run_left--;
        rx_next = rx_run_high;
      end
    endcase
    if (rx_always) rx_next = 1'b1;
    note_results.ready <= rx_next;
  end

  // ---------------------------------------------------------------------------
  // sender: every task call starts and ends just after a falling edge
  // ---------------------------------------------------------------------------

  // one character request, held until taken, with burst gaps in between
  task automatic send_char(input logic [7:0] c);
    int gap;
    if (tx_bursty && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = $urandom_range(1, 8);
      name_chars.valid <= 1'b0;
      name_chars.char_code <= 8'($urandom_range(0, 255));
      repeat (gap) @(negedge clk);
    end
    name_chars.valid     <= 1'b1;
    name_chars.char_code <= c;
    @(posedge clk);
    while (!name_chars.ready) @(posedge clk);
    parse_char(c);
    chars_sent++;
    if (burst_left > 0) burst_left--;
    @(negedge clk);
  endtask

  // whole name plus terminator
  task automatic send_note(input string name);
    for (int i = 0; i < name.len(); i++) send_char(name[i]);
    send_char(CHAR_NUL);
  endtask

  // stop sending until every expected note has come back
  task automatic wait_for_notes();
    name_chars.valid <= 1'b0;
    while (expected_notes.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_space();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? CHAR_SPACE : 8'(CHAR_TAB + k);
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // extremes of the table, both letter cases, every accidental spelling but
  // upper case f, and ways a name can go wrong
  task automatic test_directed_notes();
    send_note("A4");       // concert pitch
    send_note("c0");       // lowest entry, lower case letter
    send_note("B8");       // highest entry
    send_note("\tg#3");    // leading whitespace, hash sharp
    send_note("Bs-0");     // b sharp wraps up into octave 1
    send_note("Cb0");      // c flat wraps below octave 0
    send_note("Df+2");     // f flat, explicit plus sign
    send_note("ES4");      // upper case s sharp
    send_note("bB 5zz");   // upper case b flat, gap, ignored tail
    send_note("E 9");      // octave above 8
    send_note("A99x");     // saturating magnitude
    send_note("F-");       // sign without digits
    send_note("H1");       // no letter
    send_note("A");        // no octave
    send_note("");         // bare terminator
    // vertical tab and carriage return skipped, then a high code where the
    // letter belongs, so the rest is ignored
    send_char(8'h0B);
    send_char(CHAR_CR);
    send_char(8'hC1);
    send_note("A4");
    wait_for_notes();
  endtask

  // no gaps on either side, terminators back to back with the receiver always
  // ready, so a terminator never waits on the previous result
  task automatic test_back_to_back();
    tx_bursty = 1'b0;
    rx_always = 1'b1;
    send_note("G#7");
    send_char(CHAR_NUL);
    send_char(CHAR_NUL);
    send_note("Bb1");
    send_note("d-1");
    send_char(CHAR_NUL);
    wait_for_notes();
    rx_always = 1'b0;
    tx_bursty = 1'b1;
  endtask

  // mostly well-formed names with random content, some broken ones and
  // some plain noise
  task automatic send_random_note();
    logic [7:0] chars [$];
    int         kind;
    int         pos;
    int         n;
    int         k;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      n = $urandom_range(0, 6);
      repeat (n) chars.push_back(8'($urandom_range(1, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) chars.push_back(pick_space());
      k = $urandom_range(0, 6);
      chars.push_back(8'(($urandom_range(0, 1) ? CHAR_LO_A : CHAR_UP_A) + k));
      case ($urandom_range(0, 3))
        1: begin
          k = $urandom_range(0, 2);
          chars.push_back(k == 0 ? CHAR_HASH : (k == 1 ? CHAR_LO_S : CHAR_UP_S));
        end
        2: begin
          k = $urandom_range(0, 3);
          chars.push_back(k == 0 ? CHAR_LO_B : k == 1 ? CHAR_UP_B :
                          k == 2 ? CHAR_LO_F : CHAR_UP_F);
        end
        default: ;
      endcase
      repeat ($urandom_range(0, 1) * $urandom_range(1, 2)) chars.push_back(pick_space());
      k = $urandom_range(0, 5);
      if (k == 0) chars.push_back(CHAR_MINUS);
      else if (k == 1) chars.push_back(CHAR_PLUS);
      n = ($urandom_range(0, 9) < 7) ? 1 : $urandom_range(2, 3);
      repeat (n) chars.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
      if ($urandom_range(0, 9) < 3)
        repeat ($urandom_range(1, 3)) chars.push_back(8'($urandom_range(1, 255)));
      // broken names: drop or overwrite one character
      if (kind < 24) begin
        pos = $urandom_range(0, chars.size() - 1);
        if ($urandom_range(0, 1)) chars.delete(pos);
        else chars[pos] = 8'($urandom_range(1, 255));
      end
    end
    foreach (chars[i]) send_char(chars[i]);
    send_char(CHAR_NUL);
  endtask

  task automatic test_random_notes();
    while (chars_sent < CHAR_TARGET) begin
      // now and then a stretch without sender gaps
      if ($urandom_range(0, 15) == 0) tx_bursty = !tx_bursty;
      send_random_note();
      // hold off until the parser has answered everything
      if ($urandom_range(0, 19) == 0) wait_for_notes();
    end
    tx_bursty = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n                = 1'b0;
    name_chars.valid     = 1'b0;
    name_chars.char_code = 8'h00;
    note_results.ready   = 1'b0;
    idle_cycles          = 0;
    chars_sent           = 0;
    notes_checked        = 0;
    notes_ok             = 0;
    notes_malformed      = 0;
    notes_range          = 0;
    error_count          = 0;
    tx_bursty            = 1'b1;
    burst_left           = 0;
    rx_always            = 1'b0;
    rx_mode              = 0;
    rx_cycle             = 0;
    rx_run_left          = 0;
    rx_run_high          = 1'b0;
    clear_parser();

    // synchronous reset, released just after a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_notes();
    test_back_to_back();
    test_random_notes();

    // let the last results out, then wait DRAIN_CYCLES more for anything stray
    wait_for_notes();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (expected_notes.size() != 0) begin
      $error("%0d expected results never arrived", expected_notes.size());
      error_count++;
    end

    $display("sent %0d characters, checked %0d note results", chars_sent, notes_checked);
    $display("results by status: %0d ok, %0d malformed, %0d out of range",
             notes_ok, notes_malformed, notes_range);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
design/nnf_pkg.sv
design/nnf_if.sv
design/nnf_parse.sv
design/note_name_to_frequency_parser.sv
tb/sv/tb_top.sv
